/* design/usmg_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// usmg_pkg: shared types and constants of the UV-sphere mesh generator
// Holds the fixed-point constants, the arctangent table of the CORDIC steps
// and the structures that move between the cells of the pipeline.
// ============================================================================
package usmg_pkg;

  // Dividend width of the long division chain and widths of the CORDIC datapath.
  localparam int DivW = 40;
  localparam int XW = 34;
  localparam int AW = 35;
  localparam int CornerW = 13;
  localparam int MaxSteps = 24;

  // Number of division lanes: two angles and two texture coordinates.
  localparam int Lanes = 4;
  localparam int LaneTheta = 0;
  localparam int LanePhi = 1;
  localparam int LaneTexU = 2;
  localparam int LaneTexV = 3;

  localparam logic [DivW-1:0] PiQ30 = 40'd3373259426;
  localparam logic [DivW-1:0] TwoPiQ30 = 40'd6746518852;
  localparam logic signed [AW-1:0] PiA = 35'sd3373259426;
  localparam logic signed [AW-1:0] TwoPiA = 35'sd6746518852;
  localparam logic signed [AW-1:0] HalfPiA = 35'sd1686629713;
  localparam logic signed [XW-1:0] GainQ30 = 34'sd652032874;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_RING_COUNT = 2'd0,
    CFG_RADIUS_MAG = 2'd1,
    CFG_RADIUS_EXP = 2'd2
  } cfg_idx_e;

  // What kind of result an item turns into.
  typedef enum logic [2:0] {
    KIND_ZERO,
    KIND_TOP,
    KIND_BOT,
    KIND_MID,
    KIND_TRI
  } kind_e;

  // Fields that ride along the pipeline; tex_u and tex_v are filled in after the divider chain.
  typedef struct packed {
    kind_e               kind;
    logic [15:0]         radius;
    logic [7:0]          expo;
    logic [CornerW-1:0]  ca;
    logic [CornerW-1:0]  cb;
    logic [CornerW-1:0]  cc;
    logic [15:0]         tex_u;
    logic [15:0]         tex_v;
  } side_t;

  // One lane of the restoring divider.
  typedef struct packed {
    logic [DivW-1:0] dvd;
    logic [7:0]      dvs;
    logic [7:0]      rem;
    logic [DivW-1:0] quo;
  } lane_t;

  typedef struct packed {
    side_t                 side;
    lane_t [Lanes-1:0]     lane;
  } div_t;

  // Two CORDIC rotations side by side: theta and phi.
  typedef struct packed {
    side_t                 side;
    logic signed [XW-1:0]  xt;
    logic signed [XW-1:0]  yt;
    logic signed [AW-1:0]  at;
    logic                  nt;
    logic signed [XW-1:0]  xp;
    logic signed [XW-1:0]  yp;
    logic signed [AW-1:0]  ap;
    logic                  np;
  } cor_t;

  // atan(2^-k) in Q30.
  function automatic logic [31:0] atan_q30(input int k);
    logic [31:0] v;
    case (k)
      0: v = 32'd843314856;
      1: v = 32'd497837829;
      2: v = 32'd263043836;
      3: v = 32'd133525158;
      4: v = 32'd67021686;
      5: v = 32'd33543515;
      6: v = 32'd16775850;
      7: v = 32'd8388437;
      8: v = 32'd4194282;
      9: v = 32'd2097149;
      10: v = 32'd1048575;
      11: v = 32'd524287;
      12: v = 32'd262143;
      13: v = 32'd131071;
      14: v = 32'd65535;
      15: v = 32'd32767;
      16: v = 32'd16383;
      17: v = 32'd8191;
      18: v = 32'd4095;
      19: v = 32'd2047;
      20: v = 32'd1023;
      21: v = 32'd511;
      22: v = 32'd255;
      23: v = 32'd127;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* design/usmg_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// usmg_if: channel interfaces of the UV-sphere mesh generator
// Request, result and configuration channels with valid/ready handshakes.
// ============================================================================

// Request channel: one mesh element per item.
interface usmg_req_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [6:0] ring;
  logic [6:0] segment;
  logic       quad_half;

  modport source (output valid, command, ring, segment, quad_half, input ready);
  modport sink (input valid, command, ring, segment, quad_half, output ready);
endinterface

// Result channel: one result item per request.
interface usmg_res_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic signed [16:0] pos_z;
  logic signed [7:0]  pos_w;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic [15:0]        tex_u;
  logic [15:0]        tex_v;
  logic [12:0]        corner_a;
  logic [12:0]        corner_b;
  logic [12:0]        corner_c;

  modport source (output valid, pos_x, pos_y, pos_z, pos_w, norm_x, norm_y, norm_z,
                  tex_u, tex_v, corner_a, corner_b, corner_c, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, pos_w, norm_x, norm_y, norm_z,
                tex_u, tex_v, corner_a, corner_b, corner_c, output ready);
endinterface

// Configuration write channel.
interface usmg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/usmg_div_cell.sv */
`timescale 1ns / 1ps
// ============================================================================
// usmg_div_cell: one bit of the restoring divider chain
// Brings down one dividend bit into each lane's remainder and produces one
// quotient bit per lane, then hands the item to the next cell.
// ============================================================================
module usmg_div_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  usmg_pkg::div_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output usmg_pkg::div_t out_data_o
);

  logic           valid_q;
  usmg_pkg::div_t data_q, data_d;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // One compare and subtract per lane.
  always_comb begin
    logic [8:0] t;
    logic       ge;
    data_d = in_data_i;
    for (int l = 0; l < usmg_pkg::Lanes; l++) begin
      t  = {in_data_i.lane[l].rem, in_data_i.lane[l].dvd[Bit]};
      ge = t >= {1'b0, in_data_i.lane[l].dvs};
      data_d.lane[l].rem = ge ? 8'(t - {1'b0, in_data_i.lane[l].dvs}) : t[7:0];
      data_d.lane[l].quo = {in_data_i.lane[l].quo[usmg_pkg::DivW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

/* design/usmg_cordic_cell.sv */
`timescale 1ns / 1ps
// ============================================================================
// usmg_cordic_cell: one rotation step for both angles
// Rotates the theta and the phi vector by atan(2^-Step) toward zero residual
// angle and hands the item to the next cell.
// ============================================================================
module usmg_cordic_cell #(
  parameter int unsigned Step = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  usmg_pkg::cor_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output usmg_pkg::cor_t out_data_o
);

  localparam logic signed [usmg_pkg::AW-1:0] Atan =
    $signed({3'b000, usmg_pkg::atan_q30(Step)});

  logic           valid_q;
  usmg_pkg::cor_t data_q, data_d;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Rotation direction follows the sign of the residual angle.
  always_comb begin
    logic signed [usmg_pkg::XW-1:0] xs_t, ys_t, xs_p, ys_p;
    data_d = in_data_i;
    xs_t = $signed(in_data_i.xt) >>> Step;
    ys_t = $signed(in_data_i.yt) >>> Step;
    xs_p = $signed(in_data_i.xp) >>> Step;
    ys_p = $signed(in_data_i.yp) >>> Step;
    if (!in_data_i.at[usmg_pkg::AW-1]) begin
      data_d.xt = in_data_i.xt - ys_t;
      data_d.yt = in_data_i.yt + xs_t;
      data_d.at = in_data_i.at - Atan;
    end else begin
      data_d.xt = in_data_i.xt + ys_t;
      data_d.yt = in_data_i.yt - xs_t;
      data_d.at = in_data_i.at + Atan;
    end
    if (!in_data_i.ap[usmg_pkg::AW-1]) begin
      data_d.xp = in_data_i.xp - ys_p;
      data_d.yp = in_data_i.yp + xs_p;
      data_d.ap = in_data_i.ap - Atan;
    end else begin
      data_d.xp = in_data_i.xp + ys_p;
      data_d.yp = in_data_i.yp - xs_p;
      data_d.ap = in_data_i.ap + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

/* design/uv_sphere_mesh_generator.sv */
`timescale 1ns / 1ps
// ============================================================================
// uv_sphere_mesh_generator: vertex and triangle generator for a UV sphere
// Pipeline of divider cells, CORDIC cells and three product stages.
// ============================================================================
// Usage:
//   req_i carries one request item: a vertex (command 0) or a triangle
//   (command 1) addressed by ring, segment and quad_half. res_o returns
//   exactly one result item per request, in request order. cfg_i writes the
//   ring count, radius and exponent; it is always ready and must only be
//   written while no request is in flight.
// Pipeline and throughput:
//   Every item passes 40 divider cells (one quotient bit each), CORDIC_STEPS
//   rotation cells and three product stages. One item is accepted per cycle
//   while the chain does not stall; every cell holds one item and passes it on
//   each cycle unless the cell after it is full and not ready.
// Reset:
//   rst_ni clears all valid flags and loads ring count 16, radius 1 and
//   exponent 0. No clearing pass is needed.
// Stall:
//   When res_o is not taken, items pile up behind the output register; a
//   cell stays ready while it is empty, so req_i keeps accepting until the
//   whole chain is full.
// ============================================================================
module uv_sphere_mesh_generator #(
  parameter int MAX_RINGS = 64,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  usmg_req_if.sink    req_i,
  usmg_res_if.source  res_o,
  usmg_cfg_if.sink    cfg_i
);

  localparam int DivW = usmg_pkg::DivW;
  localparam int AW = usmg_pkg::AW;

  // Configuration registers.
  logic [6:0]  ring_count_q;
  logic [15:0] radius_q;
  logic [7:0]  expo_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_count_q <= 7'd16;
      radius_q     <= 16'd1;
      expo_q       <= 8'd0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        usmg_pkg::CFG_RING_COUNT: ring_count_q <= cfg_i.data[6:0];
        usmg_pkg::CFG_RADIUS_MAG: radius_q <= cfg_i.data;
        usmg_pkg::CFG_RADIUS_EXP: expo_q <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  // Request decode: clamp the ring count, classify and build the dividends.
  logic [6:0]     lc;
  usmg_pkg::div_t div_in;

  always_comb begin
    logic [6:0]  ring, seg;
    logic [7:0]  wv;
    logic [13:0] base, up, dn, ll;
    if (ring_count_q < 7'd2) begin
      lc = 7'd2;
    end else if (int'(ring_count_q) > MAX_RINGS) begin
      lc = 7'(MAX_RINGS);
    end else begin
      lc = ring_count_q;
    end
    ring = req_i.ring;
    seg  = req_i.segment;
    wv   = {1'b0, lc} + 8'd1;
    base = 14'd1 + 14'(wv) * 14'(lc - 7'd2);
    up   = 14'(wv) * 14'(ring - 7'd1) + 14'(seg) + 14'd1;
    dn   = 14'(wv) * 14'(ring) + 14'(seg) + 14'd1;
    ll   = 14'(lc) * 14'(lc);

    div_in = '0;
    div_in.side.kind   = usmg_pkg::KIND_ZERO;
    div_in.side.radius = radius_q;
    div_in.side.expo   = expo_q;
    if (!req_i.command) begin
      if (ring <= lc && seg <= lc) begin
        if (ring == 7'd0) begin
          div_in.side.kind = usmg_pkg::KIND_TOP;
        end else if (ring == lc) begin
          div_in.side.kind = usmg_pkg::KIND_BOT;
        end else begin
          div_in.side.kind = usmg_pkg::KIND_MID;
        end
      end
    end else if (ring <= lc - 7'd1 && seg <= lc - 7'd1) begin
      div_in.side.kind = usmg_pkg::KIND_TRI;
      if (ring == 7'd0) begin
        div_in.side.ca = '0;
        div_in.side.cb = 13'(14'(seg) + 14'd1);
        div_in.side.cc = 13'(14'(seg) + 14'd2);
      end else if (ring == lc - 7'd1) begin
        div_in.side.ca = 13'(base + 14'(seg));
        div_in.side.cb = 13'(base + 14'(seg) + 14'd1);
        div_in.side.cc = 13'(ll);
      end else if (!req_i.quad_half) begin
        div_in.side.ca = 13'(up);
        div_in.side.cb = 13'(dn);
        div_in.side.cc = 13'(dn + 14'd1);
      end else begin
        div_in.side.ca = 13'(up + 14'd1);
        div_in.side.cb = 13'(up);
        div_in.side.cc = 13'(dn + 14'd1);
      end
    end
    div_in.lane[usmg_pkg::LaneTheta].dvd = DivW'(ring) * usmg_pkg::PiQ30;
    div_in.lane[usmg_pkg::LaneTheta].dvs = {1'b0, lc};
    div_in.lane[usmg_pkg::LanePhi].dvd   = DivW'(seg) * usmg_pkg::TwoPiQ30;
    div_in.lane[usmg_pkg::LanePhi].dvs   = {1'b0, lc};
    div_in.lane[usmg_pkg::LaneTexU].dvd  = (DivW'(seg) << 17) + DivW'(lc);
    div_in.lane[usmg_pkg::LaneTexU].dvs  = {lc, 1'b0};
    div_in.lane[usmg_pkg::LaneTexV].dvd  = (DivW'(lc - ring) << 17) + DivW'(lc);
    div_in.lane[usmg_pkg::LaneTexV].dvs  = {lc, 1'b0};
  end

  // Divider chain, most significant dividend bit first.
  logic           div_v [DivW+1];
  logic           div_r [DivW+1];
  usmg_pkg::div_t div_d [DivW+1];

  assign div_v[0]    = req_i.valid;
  assign req_i.ready = div_r[0];
  assign div_d[0]    = div_in;

  for (genvar k = 0; k < DivW; k++) begin : g_div
    usmg_div_cell #(
      .Bit(DivW - 1 - k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (div_v[k]),
      .in_ready_o (div_r[k]),
      .in_data_i  (div_d[k]),
      .out_valid_o(div_v[k+1]),
      .out_ready_i(div_r[k+1]),
      .out_data_o (div_d[k+1])
    );
  end

  // Fold both angles into [-pi/2, pi/2] and finish the texture coordinates.
  function automatic logic [15:0] sat_tex(input logic [DivW-1:0] q);
    return (q[DivW-1:16] != '0) ? 16'hFFFF : q[15:0];
  endfunction

  usmg_pkg::cor_t cor_in;

  always_comb begin
    logic signed [AW-1:0] at, ap;
    logic                 nt, np;
    at = $signed({1'b0, div_d[DivW].lane[usmg_pkg::LaneTheta].quo[AW-2:0]});
    ap = $signed({1'b0, div_d[DivW].lane[usmg_pkg::LanePhi].quo[AW-2:0]});
    nt = 1'b0;
    np = 1'b0;
    if (at > usmg_pkg::PiA) at = at - usmg_pkg::TwoPiA;
    if (at > usmg_pkg::HalfPiA) begin
      at = at - usmg_pkg::PiA;
      nt = 1'b1;
    end else if (at < -usmg_pkg::HalfPiA) begin
      at = at + usmg_pkg::PiA;
      nt = 1'b1;
    end
    if (ap > usmg_pkg::PiA) ap = ap - usmg_pkg::TwoPiA;
    if (ap > usmg_pkg::HalfPiA) begin
      ap = ap - usmg_pkg::PiA;
      np = 1'b1;
    end else if (ap < -usmg_pkg::HalfPiA) begin
      ap = ap + usmg_pkg::PiA;
      np = 1'b1;
    end
    cor_in.side       = div_d[DivW].side;
    cor_in.side.tex_u = sat_tex(div_d[DivW].lane[usmg_pkg::LaneTexU].quo);
    cor_in.side.tex_v = sat_tex(div_d[DivW].lane[usmg_pkg::LaneTexV].quo);
    cor_in.xt = usmg_pkg::GainQ30;
    cor_in.yt = '0;
    cor_in.at = at;
    cor_in.nt = nt;
    cor_in.xp = usmg_pkg::GainQ30;
    cor_in.yp = '0;
    cor_in.ap = ap;
    cor_in.np = np;
  end

  // CORDIC chain.
  logic           cor_v [CORDIC_STEPS+1];
  logic           cor_r [CORDIC_STEPS+1];
  usmg_pkg::cor_t cor_d [CORDIC_STEPS+1];

  assign cor_v[0]    = div_v[DivW];
  assign div_r[DivW] = cor_r[0];
  assign cor_d[0]    = cor_in;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cor
    usmg_cordic_cell #(
      .Step(k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (cor_v[k]),
      .in_ready_o (cor_r[k]),
      .in_data_i  (cor_d[k]),
      .out_valid_o(cor_v[k+1]),
      .out_ready_i(cor_r[k+1]),
      .out_data_o (cor_d[k+1])
    );
  end

  // Product stage 1: apply the fold sign to sine and cosine.
  logic                p1_v_q, p1_rdy;
  usmg_pkg::side_t     p1_side_q;
  logic signed [31:0]  p1_st_q, p1_ct_q, p1_sp_q, p1_cp_q;
  logic                p2_v_q, p2_rdy;
  usmg_pkg::side_t     p2_side_q;
  logic signed [31:0]  p2_sxs_q, p2_czs_q, p2_ct_q;
  logic                p3_v_q, p3_rdy;

  assign p3_rdy = !p3_v_q || res_o.ready;
  assign p2_rdy = !p2_v_q || p3_rdy;
  assign p1_rdy = !p1_v_q || p2_rdy;
  assign cor_r[CORDIC_STEPS] = p1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
    end else begin
      if (p1_rdy) p1_v_q <= cor_v[CORDIC_STEPS];
      if (p2_rdy) p2_v_q <= p1_v_q;
      if (p3_rdy) p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_rdy && cor_v[CORDIC_STEPS]) begin
      p1_side_q <= cor_d[CORDIC_STEPS].side;
      p1_st_q <= cor_d[CORDIC_STEPS].nt ? 32'(-cor_d[CORDIC_STEPS].yt)
                                        : 32'(cor_d[CORDIC_STEPS].yt);
      p1_ct_q <= cor_d[CORDIC_STEPS].nt ? 32'(-cor_d[CORDIC_STEPS].xt)
                                        : 32'(cor_d[CORDIC_STEPS].xt);
      p1_sp_q <= cor_d[CORDIC_STEPS].np ? 32'(-cor_d[CORDIC_STEPS].yp)
                                        : 32'(cor_d[CORDIC_STEPS].yp);
      p1_cp_q <= cor_d[CORDIC_STEPS].np ? 32'(-cor_d[CORDIC_STEPS].xp)
                                        : 32'(cor_d[CORDIC_STEPS].xp);
    end
  end

  // Product stage 2: sin(phi) sin(theta) and cos(phi) sin(theta), Q30.
  logic signed [63:0] m_sxs, m_czs, r_sxs, r_czs;

  always_comb begin
    m_sxs = p1_sp_q * p1_st_q;
    m_czs = p1_cp_q * p1_st_q;
    r_sxs = (m_sxs + 64'sd536870912) >>> 30;
    r_czs = (m_czs + 64'sd536870912) >>> 30;
  end

  always_ff @(posedge clk_i) begin
    if (p2_rdy && p1_v_q) begin
      p2_side_q <= p1_side_q;
      p2_sxs_q  <= r_sxs[31:0];
      p2_czs_q  <= r_czs[31:0];
      p2_ct_q   <= p1_ct_q;
    end
  end

  // Product stage 3: scale by the radius, round the normals, build the result.
  function automatic logic signed [16:0] sat_pos(input logic signed [48:0] v);
    if (v > 49'sd65535) return 17'sd65535;
    if (v < -49'sd65535) return -17'sd65535;
    return v[16:0];
  endfunction

  function automatic logic signed [15:0] sat_norm(input logic signed [31:0] v);
    logic signed [32:0] t;
    t = ($signed({v[31], v}) + 33'sd16384) >>> 15;
    if (t > 33'sd32767) return 16'sh7FFF;
    if (t < -33'sd32768) return 16'sh8000;
    return t[15:0];
  endfunction

  logic signed [48:0] px, py, pz;
  logic signed [16:0] rs;

  always_comb begin
    rs = $signed({1'b0, p2_side_q.radius});
    px = (rs * p2_sxs_q + 49'sd536870912) >>> 30;
    py = (rs * p2_ct_q + 49'sd536870912) >>> 30;
    pz = (rs * p2_czs_q + 49'sd536870912) >>> 30;
  end

  // Result fields by kind; unused fields stay zero.
  logic signed [16:0] pos_x_d, pos_y_d, pos_z_d;
  logic signed [7:0]  pos_w_d;
  logic signed [15:0] norm_x_d, norm_y_d, norm_z_d;
  logic [15:0]        tex_u_d, tex_v_d;
  logic [12:0]        corner_a_d, corner_b_d, corner_c_d;

  always_comb begin
    pos_x_d    = '0;
    pos_y_d    = '0;
    pos_z_d    = '0;
    pos_w_d    = '0;
    norm_x_d   = '0;
    norm_y_d   = '0;
    norm_z_d   = '0;
    tex_u_d    = '0;
    tex_v_d    = '0;
    corner_a_d = '0;
    corner_b_d = '0;
    corner_c_d = '0;
    case (p2_side_q.kind)
      usmg_pkg::KIND_TOP: begin
        pos_y_d  = rs;
        pos_w_d  = p2_side_q.expo;
        norm_y_d = 16'sh7FFF;
        tex_u_d  = 16'h8000;
        tex_v_d  = 16'hFFFF;
      end
      usmg_pkg::KIND_BOT: begin
        pos_y_d  = -rs;
        pos_w_d  = p2_side_q.expo;
        norm_y_d = 16'sh8000;
        tex_u_d  = 16'h8000;
      end
      usmg_pkg::KIND_MID: begin
        pos_x_d = sat_pos(px);
        pos_y_d = sat_pos(py);
        pos_z_d = sat_pos(pz);
        pos_w_d = p2_side_q.expo;
        if (p2_side_q.radius != '0) begin
          norm_x_d = sat_norm(p2_sxs_q);
          norm_y_d = sat_norm(p2_ct_q);
          norm_z_d = sat_norm(p2_czs_q);
        end
        tex_u_d = p2_side_q.tex_u;
        tex_v_d = p2_side_q.tex_v;
      end
      usmg_pkg::KIND_TRI: begin
        corner_a_d = p2_side_q.ca;
        corner_b_d = p2_side_q.cb;
        corner_c_d = p2_side_q.cc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (p3_rdy && p2_v_q) begin
      res_o.pos_x    <= pos_x_d;
      res_o.pos_y    <= pos_y_d;
      res_o.pos_z    <= pos_z_d;
      res_o.pos_w    <= pos_w_d;
      res_o.norm_x   <= norm_x_d;
      res_o.norm_y   <= norm_y_d;
      res_o.norm_z   <= norm_z_d;
      res_o.tex_u    <= tex_u_d;
      res_o.tex_v    <= tex_v_d;
      res_o.corner_a <= corner_a_d;
      res_o.corner_b <= corner_b_d;
      res_o.corner_c <= corner_c_d;
    end
  end

  assign res_o.valid = p3_v_q;

  // An empty output register means every cell before it can take an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !p3_v_q |-> req_i.ready)
    else $error("request channel stalled with an empty output register");

  // A triangle result carries nothing but its corners.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.corner_a != '0 || res_o.corner_b != '0 ||
                     res_o.corner_c != '0))
    |-> (res_o.pos_x == '0 && res_o.pos_y == '0 && res_o.pos_z == '0 &&
         res_o.pos_w == '0 && res_o.norm_y == '0 && res_o.tex_u == '0))
    else $error("triangle result carries vertex fields");

  // A held result keeps its corners while the receiver stalls the chain behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> (p3_v_q && $stable(res_o.corner_a)))
    else $error("stalled result changed");

endmodule

/* bench/uv_sphere_mesh_generator_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// uv_sphere_mesh_generator_tb: self-checking bench for the UV-sphere generator
// Sends vertex and triangle requests under several sphere settings, predicts
// every result with an independent fixed-point model of the sphere, and
// checks the results in order while both channels idle and stall at random.
// ============================================================================
module uv_sphere_mesh_generator_tb;

  localparam int Steps = 16;
  localparam int MaxRings = 64;
  localparam int Latency = 43 + Steps;
  localparam longint PiFix = 64'd3373259426;
  localparam longint TwoPiFix = 64'd6746518852;
  localparam longint HalfPiFix = 64'd1686629713;
  localparam longint GainFix = 64'd652032874;
  localparam longint AngleStep [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127};

  typedef struct packed {
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic signed [16:0] pz;
    logic signed [7:0]  pw;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [15:0]        tu;
    logic [15:0]        tv;
    logic [12:0]        ca;
    logic [12:0]        cb;
    logic [12:0]        cc;
  } mesh_res_t;

  // Sphere predictor and in-order store of expected mesh elements.
  class MeshScoreboard;
    logic [6:0]  rings;
    logic [15:0] radius;
    logic [7:0]  expo;
    mesh_res_t   pending[$];
    int          mismatches;

    function new();
      rings = 7'd16;
      radius = 16'd1;
      expo = 8'd0;
      mismatches = 0;
    endfunction

    function int eff_rings();
      if (rings < 2) return 2;
      if (rings > MaxRings) return MaxRings;
      return int'(rings);
    endfunction

    function longint round_shift(longint v, int k);
      return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint tex_frac(longint n, longint l);
      longint q;
      q = (n * 131072 + l) / (2 * l);
      return q > 65535 ? 65535 : q;
    endfunction

    // Fixed-iteration rotation after folding the angle into the right half plane.
    function void rotate(longint a, output longint s, output longint c);
      bit     flip;
      longint x, y, t;
      flip = 0;
      x = GainFix;
      y = 0;
      if (a > PiFix) a -= TwoPiFix;
      if (a > HalfPiFix) begin
        a -= PiFix;
        flip = 1;
      end else if (a < -HalfPiFix) begin
        a += PiFix;
        flip = 1;
      end
      for (int k = 0; k < Steps; k++) begin
        if (a >= 0) begin
          t = x - (y >>> k); y = y + (x >>> k); x = t; a -= AngleStep[k];
        end else begin
          t = x + (y >>> k); y = y - (x >>> k); x = t; a += AngleStep[k];
        end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function mesh_res_t predict(bit cmd, int ring, int seg, bit half);
      mesh_res_t e;
      longint l, r, st, ct, sp, cp, sxs, czs, w, base, up, dn;
      e = '0;
      l = longint'(eff_rings());
      r = longint'(radius);
      if (!cmd) begin
        if (ring <= l && seg <= l) begin
          e.pw = expo;
          if (ring == 0 || ring == l) begin
            e.py = 17'((ring == 0) ? r : -r);
            e.ny = (ring == 0) ? 16'sd32767 : -16'sd32768;
            e.tu = 16'd32768;
            e.tv = (ring == 0) ? 16'd65535 : 16'd0;
          end else begin
            rotate(longint'(ring) * PiFix / l, st, ct);
            rotate(longint'(seg) * TwoPiFix / l, sp, cp);
            sxs = round_shift(sp * st, 30);
            czs = round_shift(cp * st, 30);
            e.px = 17'(clip(round_shift(r * sxs, 30), -65535, 65535));
            e.py = 17'(clip(round_shift(r * ct, 30), -65535, 65535));
            e.pz = 17'(clip(round_shift(r * czs, 30), -65535, 65535));
            if (r != 0) begin
              e.nx = 16'(clip(round_shift(sxs, 15), -32768, 32767));
              e.ny = 16'(clip(round_shift(ct, 15), -32768, 32767));
              e.nz = 16'(clip(round_shift(czs, 15), -32768, 32767));
            end
            e.tu = 16'(tex_frac(longint'(seg), l));
            e.tv = 16'(tex_frac(l - ring, l));
          end
        end
      end else if (ring <= l - 1 && seg <= l - 1) begin
        w = l + 1;
        if (ring == 0) begin
          e.cb = 13'(1 + seg);
          e.cc = 13'(2 + seg);
        end else if (ring == l - 1) begin
          base = 1 + w * (l - 2);
          e.ca = 13'(base + seg);
          e.cb = 13'(base + seg + 1);
          e.cc = 13'(l * l);
        end else begin
          up = w * (ring - 1) + seg + 1;
          dn = w * ring + seg + 1;
          e.ca = 13'(half ? up + 1 : up);
          e.cb = 13'(half ? up : dn);
          e.cc = 13'(dn + 1);
        end
      end
      return e;
    endfunction

    function void note_request(bit cmd, int ring, int seg, bit half);
      pending = {pending, predict(cmd, ring, seg, half)};
    endfunction

    function void check_result(mesh_res_t got);
      mesh_res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result item with nothing expected");
        return;
      end
      want = pending.pop_front();
      if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz ||
          got.pw !== want.pw || got.nx !== want.nx || got.ny !== want.ny ||
          got.nz !== want.nz || got.tu !== want.tu || got.tv !== want.tv ||
          got.ca !== want.ca || got.cb !== want.cb || got.cc !== want.cc) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: mismatch at %0t", $realtime);
          $display("  expected pos %0d %0d %0d w %0d norm %0d %0d %0d tex %0d %0d tri %0d %0d %0d",
                   want.px, want.py, want.pz, want.pw, want.nx, want.ny, want.nz,
                   want.tu, want.tv, want.ca, want.cb, want.cc);
          $display("  actual   pos %0d %0d %0d w %0d norm %0d %0d %0d tex %0d %0d tri %0d %0d %0d",
                   got.px, got.py, got.pz, got.pw, got.nx, got.ny, got.nz,
                   got.tu, got.tv, got.ca, got.cb, got.cc);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  usmg_req_if req_if ();
  usmg_res_if res_if ();
  usmg_cfg_if cfg_if ();

  uv_sphere_mesh_generator #(
    .MAX_RINGS(MaxRings),
    .CORDIC_STEPS(Steps)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req_i(req_if.sink),
    .res_o(res_if.source),
    .cfg_i(cfg_if.sink)
  );

  always #6 clk_i = ~clk_i;

  MeshScoreboard sb = new();
  bit idle_free;
  int results_seen;

  // Mostly short gaps, now and then a long one; none while idle_free is set.
  function int pick_gap();
    if (idle_free || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one request item and waits for it to be taken.
  task automatic send_request(bit cmd, int ring, int seg, bit half);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.ring <= ring[6:0];
    req_if.segment <= seg[6:0];
    req_if.quad_half <= half;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(cmd, ring[6:0], seg[6:0], half);
  endtask

  task automatic release_request();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes one register; the model copy follows on acceptance.
  task automatic write_reg(usmg_pkg::cfg_idx_e idx, logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      usmg_pkg::CFG_RING_COUNT: sb.rings = value[6:0];
      usmg_pkg::CFG_RADIUS_MAG: sb.radius = value;
      usmg_pkg::CFG_RADIUS_EXP: sb.expo = value[7:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  // Random items: mostly in range for the current ring count, some raw noise.
  task automatic random_items(int n);
    int l, ring, seg;
    bit cmd;
    for (int i = 0; i < n; i++) begin
      l = sb.eff_rings();
      cmd = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 85) begin
        ring = cmd ? $urandom_range(0, l - 1) : $urandom_range(0, l);
        seg = cmd ? $urandom_range(0, l - 1) : $urandom_range(0, l);
      end else begin
        ring = $urandom_range(0, 127);
        seg = $urandom_range(0, 127);
      end
      if (i % 60 == 0) idle_free = ($urandom_range(0, 3) == 0);
      send_request(cmd, ring, seg, 1'($urandom_range(0, 1)));
    end
    idle_free = 0;
    release_request();
  endtask

  // Result side: random back-pressure plus one long hold-off.
  initial begin
    int hold_left;
    bit long_done;
    hold_left = 0;
    long_done = 0;
    results_seen = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        sb.check_result('{res_if.pos_x, res_if.pos_y, res_if.pos_z, res_if.pos_w,
                          res_if.norm_x, res_if.norm_y, res_if.norm_z, res_if.tex_u,
                          res_if.tex_v, res_if.corner_a, res_if.corner_b,
                          res_if.corner_c});
        results_seen++;
      end
      if (!long_done && results_seen >= 300) begin
        long_done = 1;
        hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (idle_free) begin
        res_if.ready <= 1'b1;
      end else if ($urandom_range(0, 9) < 7) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b0;
        if ($urandom_range(0, 19) == 0) hold_left = $urandom_range(10, 40);
      end
    end
  end

  // Stimulus and final verdict.
  initial begin
    req_if.valid <= 1'b0;
    req_if.command <= 1'b0;
    req_if.ring <= '0;
    req_if.segment <= '0;
    req_if.quad_half <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= usmg_pkg::CFG_RING_COUNT;
    cfg_if.data <= '0;
    idle_free = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under reset settings: poles, segment ends, caps, both quad
    // halves, and requests just past the valid range.
    send_request(0, 0, 0, 0);
    send_request(0, 0, 16, 1);
    send_request(0, 16, 5, 0);
    send_request(0, 1, 0, 0);
    send_request(0, 15, 16, 0);
    send_request(0, 8, 8, 0);
    send_request(0, 4, 12, 1);
    send_request(0, 17, 0, 0);
    send_request(0, 3, 17, 0);
    send_request(0, 127, 127, 1);
    send_request(1, 0, 0, 0);
    send_request(1, 0, 15, 1);
    send_request(1, 15, 0, 0);
    send_request(1, 15, 15, 1);
    send_request(1, 1, 0, 0);
    send_request(1, 1, 0, 1);
    send_request(1, 14, 15, 0);
    send_request(1, 14, 15, 1);
    send_request(1, 16, 0, 0);
    send_request(1, 3, 16, 1);
    send_request(1, 127, 127, 1);
    release_request();
    random_items(120);
    drain();

    // Smallest sphere, zero radius, most negative exponent.
    write_reg(usmg_pkg::CFG_RING_COUNT, 16'd2);
    write_reg(usmg_pkg::CFG_RADIUS_MAG, 16'd0);
    write_reg(usmg_pkg::CFG_RADIUS_EXP, 16'h0080);
    send_request(0, 1, 1, 0);
    send_request(1, 1, 1, 0);
    random_items(100);
    drain();

    // Largest sphere, largest radius and exponent.
    write_reg(usmg_pkg::CFG_RING_COUNT, 16'd64);
    write_reg(usmg_pkg::CFG_RADIUS_MAG, 16'hFFFF);
    write_reg(usmg_pkg::CFG_RADIUS_EXP, 16'hA57F);
    random_items(130);
    drain();

    // Ring counts outside the legal range are clamped.
    write_reg(usmg_pkg::CFG_RING_COUNT, 16'h3F80);
    write_reg(usmg_pkg::CFG_RADIUS_MAG, 16'd40000);
    write_reg(usmg_pkg::CFG_RADIUS_EXP, 16'd5);
    random_items(100);
    drain();
    write_reg(usmg_pkg::CFG_RING_COUNT, 16'h007F);
    write_reg(usmg_pkg::CFG_RADIUS_MAG, 16'd1234);
    write_reg(usmg_pkg::CFG_RADIUS_EXP, 16'h00FF);
    random_items(100);
    drain();

    // Random settings.
    repeat (3) begin
      write_reg(usmg_pkg::CFG_RING_COUNT, 16'($urandom_range(2, 64)));
      write_reg(usmg_pkg::CFG_RADIUS_MAG, 16'($urandom_range(0, 65535)));
      write_reg(usmg_pkg::CFG_RADIUS_EXP, 16'($urandom_range(0, 65535)));
      random_items(85);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(12 * 600000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
